>>> sv/htwd_pkg.sv
package htwd_pkg;

  // fixed field widths
  localparam int SYM_W     = 8;
  localparam int CODE_W    = 8;
  localparam int BITS_W    = 31;
  localparam int BIT_IDX_W = $clog2(CODE_W);

  // tree marker byte that introduces a leaf
  localparam logic [SYM_W-1:0] LEAF_MARK = 8'h31;

  typedef enum logic {
    OP_TREE = 1'b0,
    OP_CODE = 1'b1
  } op_t;

  typedef enum logic {
    SIDE_LEFT  = 1'b0,
    SIDE_RIGHT = 1'b1
  } side_t;

  // tree builder status seen by the sequencer and the walker
  typedef struct packed {
    logic complete;
    logic root_leaf;
    logic busy;
  } build_status_t;

endpackage

>>> sv/htwd_node_mem.sv
module htwd_node_mem import htwd_pkg::*; #(
  parameter int MAX_NODES = 511,
  localparam int IW = $clog2(MAX_NODES),
  localparam int SLOT_W = IW + SYM_W + 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  side_t             wr_side,
  input  logic [IW-1:0]     wr_addr,
  input  logic [SLOT_W-1:0] wr_slot,
  input  logic [IW-1:0]     rd_addr,
  output logic [SLOT_W-1:0] rd_left,
  output logic [SLOT_W-1:0] rd_right
);

  // each child slot holds {child is leaf, child symbol, child index}
  logic [SLOT_W-1:0] left_mem  [MAX_NODES];
  logic [SLOT_W-1:0] right_mem [MAX_NODES];

  // left child slots
  always_ff @(posedge clk) begin
    if (wr_en && wr_side == SIDE_LEFT) begin
      left_mem[wr_addr] <= wr_slot;
    end
    rd_left <= left_mem[rd_addr];
  end

  // right child slots
  always_ff @(posedge clk) begin
    if (wr_en && wr_side == SIDE_RIGHT) begin
      right_mem[wr_addr] <= wr_slot;
    end
    rd_right <= right_mem[rd_addr];
  end

endmodule

>>> sv/htwd_tree_builder.sv
module htwd_tree_builder import htwd_pkg::*; #(
  parameter int ALPHABET = 256,
  parameter int MAX_NODES = 511,
  localparam int IW = $clog2(MAX_NODES),
  localparam int NW = $clog2(MAX_NODES + 1),
  localparam int SW = $clog2(ALPHABET),
  localparam int DW = $clog2(ALPHABET + 1),
  localparam int SLOT_W = IW + SYM_W + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              restart,
  input  logic              load,
  input  logic [SYM_W-1:0]  tree_byte,
  output logic              wr_en,
  output side_t             wr_side,
  output logic [IW-1:0]     wr_addr,
  output logic [SLOT_W-1:0] wr_slot,
  output build_status_t     status
);

  // open node stack: the top lives in registers, the rest in memory
  logic [IW-1:0] stack_mem [ALPHABET];
  logic [IW-1:0] stack_rd;
  logic [IW-1:0] top;
  side_t         top_side;
  logic [DW-1:0] depth;

  logic [NW-1:0] nodes_used;
  logic          expect_sym;
  logic          complete;
  logic          root_leaf;
  logic          pop_pending;
  logic [IW-1:0] last_parent;
  side_t         last_side;

  logic          is_leaf;
  logic          stack_empty;
  logic          table_full;
  logic          stack_full;
  logic          take;
  logic          attach;
  logic          do_pop;
  logic          push_save;
  logic          sym_write;
  logic [IW-1:0] new_idx;
  logic [NW-1:0] used_m1;
  logic [IW-1:0] leaf_idx;
  logic [DW-1:0] depth_m1;
  logic [DW-1:0] depth_m2;
  logic [SW-1:0] push_addr;
  logic [SW-1:0] pop_addr;

  // decode of the current tree byte
  always_comb begin
    is_leaf     = (tree_byte == LEAF_MARK);
    stack_empty = (depth == '0);
    table_full  = (nodes_used >= NW'(MAX_NODES));
    stack_full  = (depth >= DW'(ALPHABET));
    take        = load && !expect_sym && !table_full &&
                  !(nodes_used != '0 && stack_empty) &&
                  !(!is_leaf && stack_full);
    new_idx     = nodes_used[IW-1:0];
    used_m1     = nodes_used - NW'(1);
    leaf_idx    = used_m1[IW-1:0];
    attach      = take && (nodes_used != '0);
    do_pop      = attach && (top_side == SIDE_RIGHT);
    push_save   = take && !is_leaf && !do_pop && !stack_empty;
    sym_write   = load && expect_sym && (nodes_used > NW'(1));
    depth_m1    = depth - DW'(1);
    depth_m2    = depth - DW'(2);
    push_addr   = depth_m1[SW-1:0];
    pop_addr    = depth_m2[SW-1:0];
  end

  // node slot writes: attach a new child, or fill in a leaf symbol
  always_comb begin
    wr_en   = 1'b0;
    wr_side = top_side;
    wr_addr = top;
    wr_slot = {is_leaf, {SYM_W{1'b0}}, new_idx};
    if (attach) begin
      wr_en = 1'b1;
    end else if (sym_write) begin
      wr_en   = 1'b1;
      wr_side = last_side;
      wr_addr = last_parent;
      wr_slot = {1'b1, tree_byte, leaf_idx};
    end
  end

  // stack memory, entry below the top read every cycle
  always_ff @(posedge clk) begin
    if (push_save) begin
      stack_mem[push_addr] <= top;
    end
    stack_rd <= stack_mem[pop_addr];
  end

  // tree build state
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      depth       <= '0;
      nodes_used  <= '0;
      expect_sym  <= 1'b0;
      complete    <= 1'b0;
      root_leaf   <= 1'b0;
      pop_pending <= 1'b0;
    end else begin
      // finish a pop: node below the top has its left child already
      if (pop_pending) begin
        top         <= stack_rd;
        top_side    <= SIDE_RIGHT;
        pop_pending <= 1'b0;
      end
      if (load && expect_sym) begin
        expect_sym <= 1'b0;
        if (stack_empty) begin
          complete <= 1'b1;
        end
      end
      if (take) begin
        nodes_used <= nodes_used + NW'(1);
        if (nodes_used == '0) begin
          root_leaf <= is_leaf;
        end
        if (attach) begin
          last_parent <= top;
          last_side   <= top_side;
        end
        if (is_leaf) begin
          expect_sym <= 1'b1;
          if (do_pop) begin
            depth       <= depth_m1;
            pop_pending <= 1'b1;
          end else if (attach) begin
            top_side <= SIDE_RIGHT;
          end
        end else begin
          // internal node becomes the new top; a full parent is replaced
          top      <= new_idx;
          top_side <= SIDE_LEFT;
          if (!do_pop) begin
            depth <= depth + DW'(1);
          end
        end
      end
    end
  end

  assign status = '{complete: complete, root_leaf: root_leaf, busy: pop_pending};

endmodule

>>> sv/htwd_walker.sv
module htwd_walker import htwd_pkg::*; #(
  parameter int MAX_NODES = 511,
  localparam int IW = $clog2(MAX_NODES),
  localparam int SLOT_W = IW + SYM_W + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              restart,
  input  logic              start,
  input  logic [CODE_W-1:0] code_in,
  input  logic [BITS_W-1:0] total_code_bits,
  input  logic              root_leaf,
  input  logic [SLOT_W-1:0] rd_left,
  input  logic [SLOT_W-1:0] rd_right,
  output logic [IW-1:0]     rd_addr,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SYM_W-1:0]  symbol,
  output logic              last_of_byte,
  output logic              stream_done
);

  typedef enum logic [1:0] {
    W_IDLE,
    W_BITS,
    W_FLUSH
  } walk_state_t;

  walk_state_t          state;
  logic [CODE_W-1:0]    code;
  logic [BIT_IDX_W-1:0] bit_idx;
  logic [IW-1:0]        pos;
  logic [IW-1:0]        pos_next;
  logic [BITS_W-1:0]    bits_consumed;
  logic                 pend_valid;
  logic [SYM_W-1:0]     pend_sym;
  logic                 pend_done;

  logic [SLOT_W-1:0]    slot;
  logic [IW-1:0]        child;
  logic                 slot_leaf;
  logic [SYM_W-1:0]     slot_sym;
  logic [BITS_W-1:0]    bits_inc;
  logic                 at_limit;
  logic                 hit;
  logic                 out_free;
  logic                 blocked;
  logic                 step;
  logic                 emit;

  // one tree level per cycle unless the output stalls; bit picks child
  always_comb begin
    slot      = code[bit_idx] ? rd_right : rd_left;
    child     = slot[IW-1:0];
    slot_leaf = slot[SLOT_W-1];
    slot_sym  = slot[SLOT_W-2 -: SYM_W];
    bits_inc  = bits_consumed + BITS_W'(1);
    at_limit  = (bits_consumed >= total_code_bits);
    hit       = !root_leaf && (child != '0) && slot_leaf;
    out_free  = !out_valid || !out_stall;
    blocked   = hit && pend_valid && !out_free;
    step      = (state == W_BITS) && !at_limit && !blocked;
    // a held symbol moves to the output register
    emit      = (step && hit && pend_valid) ||
                ((state == W_FLUSH) && pend_valid && out_free);
    pos_next  = pos;
    if (restart) begin
      pos_next = '0;
    end else if (step && !root_leaf) begin
      pos_next = (child == '0 || slot_leaf) ? '0 : child;
    end
  end

  assign rd_addr = pos_next;
  assign busy    = (state != W_IDLE);

  // walk sequencer, pending symbol and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= W_IDLE;
      pos           <= '0;
      bits_consumed <= '0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      pos <= pos_next;
      if (restart) begin
        bits_consumed <= '0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        W_IDLE: begin
          if (start) begin
            code    <= code_in;
            bit_idx <= BIT_IDX_W'(CODE_W - 1);
            state   <= W_BITS;
          end
        end
        W_BITS: begin
          if (at_limit) begin
            state <= W_FLUSH;
          end else if (!blocked) begin
            bits_consumed <= bits_inc;
            // the held symbol is known not to be the last of this byte
            if (hit) begin
              if (pend_valid) begin
                symbol       <= pend_sym;
                last_of_byte <= 1'b0;
                stream_done  <= pend_done;
              end
              pend_valid <= 1'b1;
              pend_sym   <= slot_sym;
              pend_done  <= (bits_inc == total_code_bits);
            end
            if (bit_idx == '0) begin
              state <= W_FLUSH;
            end else begin
              bit_idx <= bit_idx - BIT_IDX_W'(1);
            end
          end
        end
        W_FLUSH: begin
          // release the held symbol as the last of the byte
          if (!pend_valid) begin
            state <= W_IDLE;
          end else if (out_free) begin
            symbol       <= pend_sym;
            last_of_byte <= 1'b1;
            stream_done  <= pend_done;
            pend_valid   <= 1'b0;
            state        <= W_IDLE;
          end
        end
        default: begin
          state <= W_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/huffman_tree_walk_decoder.sv
// Tree transactions load the builder; popping a filled node stalls the input while the
// node below the top is read back. Coded transaction: all 8 bits are walked unless the bit
// limit stops it early; both child slots of a node are read per bit; output stalls hold it.
// Results leave through an output register, one symbol held back to mark the last.
// Synchronous active-high reset clears the tree, walk position, bit count and the
// bit limit; node and stack memories need no clearing and come up unwritten.
module huffman_tree_walk_decoder import htwd_pkg::*; #(
  parameter int ALPHABET = 256,
  parameter int MAX_NODES = 511
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [BITS_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              op,
  input  logic [CODE_W-1:0] item_byte,
  input  logic              first_of_tree,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SYM_W-1:0]  symbol,
  output logic              last_of_byte,
  output logic              stream_done
);

  localparam int IW = $clog2(MAX_NODES);
  localparam int SLOT_W = IW + SYM_W + 1;

  typedef enum logic {
    ST_IDLE,
    ST_TREE
  } seq_state_t;

  seq_state_t        state;
  logic [SYM_W-1:0]  tree_byte;
  logic [BITS_W-1:0] total_code_bits;

  build_status_t     status;
  logic              walk_busy;
  logic              accept;
  logic              restart;
  logic              tree_go;
  logic              walk_go;

  logic              wr_en;
  side_t             wr_side;
  logic [IW-1:0]     wr_addr;
  logic [SLOT_W-1:0] wr_slot;
  logic [IW-1:0]     rd_addr;
  logic [SLOT_W-1:0] rd_left;
  logic [SLOT_W-1:0] rd_right;

  // input transaction decode
  always_comb begin
    in_stall = (state != ST_IDLE) || status.busy || walk_busy;
    accept   = in_valid && !in_stall;
    restart  = accept && (op == OP_TREE) && first_of_tree;
    tree_go  = accept && (op == OP_TREE) && (first_of_tree || !status.complete);
    walk_go  = accept && (op == OP_CODE) && status.complete;
  end

  // sequencer and bit limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      total_code_bits <= '0;
    end else begin
      if (cfg_we) begin
        total_code_bits <= cfg_wdata;
      end
      case (state)
        ST_IDLE: begin
          if (tree_go) begin
            tree_byte <= item_byte;
            state     <= ST_TREE;
          end
        end
        ST_TREE: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  htwd_tree_builder #(
    .ALPHABET  (ALPHABET),
    .MAX_NODES (MAX_NODES)
  ) u_builder (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .load      (state == ST_TREE),
    .tree_byte (tree_byte),
    .wr_en     (wr_en),
    .wr_side   (wr_side),
    .wr_addr   (wr_addr),
    .wr_slot   (wr_slot),
    .status    (status)
  );

  htwd_node_mem #(
    .MAX_NODES (MAX_NODES)
  ) u_node_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_side  (wr_side),
    .wr_addr  (wr_addr),
    .wr_slot  (wr_slot),
    .rd_addr  (rd_addr),
    .rd_left  (rd_left),
    .rd_right (rd_right)
  );

  htwd_walker #(
    .MAX_NODES (MAX_NODES)
  ) u_walker (
    .clk             (clk),
    .rst             (rst),
    .restart         (restart),
    .start           (walk_go),
    .code_in         (item_byte),
    .total_code_bits (total_code_bits),
    .root_leaf       (status.root_leaf),
    .rd_left         (rd_left),
    .rd_right        (rd_right),
    .rd_addr         (rd_addr),
    .busy            (walk_busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .symbol          (symbol),
    .last_of_byte    (last_of_byte),
    .stream_done     (stream_done)
  );

endmodule

>>> tb/sv/tb_huffman_tree_walk_decoder.sv
module tb_huffman_tree_walk_decoder;
  timeunit 1ns;
  timeprecision 1ps;
  import htwd_pkg::*;

  localparam logic [8:0] NODE_SLOTS = 9'd511;
  localparam logic [8:0] OPEN_SLOTS = 9'd256;
  localparam logic [BITS_W-1:0] LIMIT_MAX = 31'h7FFF_FFFF;
  // settle time for the rest of a coded transaction plus the held-back output symbol
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD = 400;
  localparam int PHASE_ITEMS = 48;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             last_flag;
    logic             done_flag;
  } decoded_sym_t;

  // tree rebuild and code walk, plus the queue of symbols still owed
  class symbol_scoreboard;
    logic              leaf_flag [NODE_SLOTS];
    logic [SYM_W-1:0]  leaf_symbol [NODE_SLOTS];
    logic [8:0]        left_kid [NODE_SLOTS];
    logic [8:0]        right_kid [NODE_SLOTS];
    logic [8:0]        open_nodes [OPEN_SLOTS];
    logic [8:0]        open_depth;
    logic [8:0]        nodes_alloc;
    logic              symbol_due;
    logic              tree_ready;
    logic [8:0]        walk_node;
    logic [BITS_W-1:0] bits_used;
    logic [BITS_W-1:0] bit_limit;
    decoded_sym_t      expected_syms[$];
    int                failures;

    function new();
      foreach (leaf_flag[i]) begin
        leaf_flag[i] = 1'b0;
        leaf_symbol[i] = '0;
        left_kid[i] = '0;
        right_kid[i] = '0;
      end
      foreach (open_nodes[i]) open_nodes[i] = '0;
      bit_limit = '0;
      failures = 0;
      restart_tree();
    endfunction

    function void restart_tree();
      open_depth = '0;
      nodes_alloc = '0;
      symbol_due = 1'b0;
      tree_ready = 1'b0;
      walk_node = '0;
      bits_used = '0;
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) $display("error: %s", msg);
    endfunction

    // one accepted input transaction: grow the tree or walk up to eight code bits
    function void note_item(op_t kind, logic [SYM_W-1:0] b, logic first);
      logic [8:0]   idx;
      logic [8:0]   top;
      logic [8:0]   child;
      logic [8:0]   pos;
      decoded_sym_t one;
      decoded_sym_t burst[$];
      if (kind == OP_TREE) begin
        if (first) restart_tree();
        if (tree_ready) return;
        if (symbol_due) begin
          if (nodes_alloc != 0) leaf_symbol[nodes_alloc - 9'd1] = b;
          symbol_due = 1'b0;
          if (open_depth == 0) tree_ready = 1'b1;
          return;
        end
        if (nodes_alloc >= NODE_SLOTS) return;
        if (nodes_alloc != 0 && open_depth == 0) return;
        if (b != LEAF_MARK && open_depth >= OPEN_SLOTS) return;
        idx = nodes_alloc;
        nodes_alloc++;
        leaf_flag[idx] = (b == LEAF_MARK);
        leaf_symbol[idx] = '0;
        left_kid[idx] = '0;
        right_kid[idx] = '0;
        // hang the node on the innermost open node, then pop filled ones
        if (idx != 0 && open_depth != 0) begin
          top = open_nodes[open_depth - 9'd1];
          if (left_kid[top] == 0) left_kid[top] = idx;
          else right_kid[top] = idx;
          while (open_depth != 0 && left_kid[open_nodes[open_depth - 9'd1]] != 0 &&
                 right_kid[open_nodes[open_depth - 9'd1]] != 0)
            open_depth--;
        end
        if (b == LEAF_MARK) begin
          symbol_due = 1'b1;
        end else begin
          open_nodes[open_depth] = idx;
          open_depth++;
        end
        return;
      end
      if (!tree_ready) return;
      // msb first walk, stop at the bit limit
      for (int i = CODE_W - 1; i >= 0; i--) begin
        if (bits_used >= bit_limit) break;
        bits_used++;
        if (leaf_flag[0]) continue;
        pos = (walk_node < NODE_SLOTS) ? walk_node : 9'd0;
        child = b[i] ? right_kid[pos] : left_kid[pos];
        if (child == 0 || child >= NODE_SLOTS) begin
          walk_node = '0;
        end else if (leaf_flag[child]) begin
          one.sym = leaf_symbol[child];
          one.last_flag = 1'b0;
          one.done_flag = (bits_used >= bit_limit);
          burst = {burst, one};
          walk_node = '0;
        end else begin
          walk_node = child;
        end
      end
      if (burst.size() != 0) burst[burst.size() - 1].last_flag = 1'b1;
      foreach (burst[k]) expected_syms = {expected_syms, burst[k]};
    endfunction

    function void check_symbol(logic [SYM_W-1:0] s, logic l, logic d);
      decoded_sym_t want;
      if (expected_syms.size() == 0) begin
        report($sformatf("unexpected symbol %02h last=%0d done=%0d", s, l, d));
        return;
      end
      want = expected_syms.pop_front();
      if (want.sym !== s || want.last_flag !== l || want.done_flag !== d)
        report($sformatf("expected sym=%02h last=%0d done=%0d, got sym=%02h last=%0d done=%0d",
                         want.sym, want.last_flag, want.done_flag, s, l, d));
    endfunction
  endclass

  logic              clk;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [BITS_W-1:0] cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              op = 1'b0;
  logic [CODE_W-1:0] item_byte = '0;
  logic              first_of_tree = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [SYM_W-1:0]  symbol;
  logic              last_of_byte;
  logic              stream_done;

  symbol_scoreboard sb;
  logic [7:0] tree_bytes[$];
  int  items_sent = 0;
  bit  idle_on = 1'b0;
  bit  stall_on = 1'b0;
  int  hold_epoch = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  int  stall_left = 0;

  huffman_tree_walk_decoder #(
    .ALPHABET(int'(OPEN_SLOTS)),
    .MAX_NODES(int'(NODE_SLOTS))
  ) uut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 8);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [7:0] internal_marker();
    logic [7:0] m;
    do m = 8'($urandom_range(255)); while (m == LEAF_MARK);
    return m;
  endfunction

  function automatic int pick_leaves();
    int r;
    r = $urandom_range(99);
    if (r < 50) return $urandom_range(2, 4);
    if (r < 85) return $urandom_range(5, 12);
    if (r < 97) return $urandom_range(13, 24);
    return $urandom_range(25, 40);
  endfunction

  // preorder bytes of a random full tree, left subtree first
  function automatic void make_tree_bytes(int leaves);
    int pend[$];
    int c;
    int k;
    tree_bytes.delete();
    pend = {pend, leaves};
    while (pend.size() != 0) begin
      c = pend.pop_back();
      if (c == 1) begin
        tree_bytes = {tree_bytes, LEAF_MARK};
        tree_bytes = {tree_bytes, 8'($urandom_range(255))};
      end else begin
        tree_bytes = {tree_bytes, internal_marker()};
        k = $urandom_range(1, c - 1);
        pend = {pend, c - k};
        pend = {pend, k};
      end
    end
  endfunction

  // one input transaction, then an optional gap
  task automatic send_item(op_t kind, logic [7:0] b, logic first);
    int gap;
    in_valid <= 1'b1;
    op <= kind;
    item_byte <= b;
    first_of_tree <= first;
    do @(posedge clk); while (in_stall);
    sb.note_item(kind, b, first);
    items_sent++;
    gap = (idle_on && $urandom_range(99) < 35) ? pick_gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_tree(int count);
    for (int i = 0; i < count; i++) send_item(OP_TREE, tree_bytes[i], i == 0);
  endtask

  task automatic send_codes(int n);
    int r;
    logic [7:0] b;
    repeat (n) begin
      r = $urandom_range(9);
      b = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(255));
      send_item(OP_CODE, b, $urandom_range(3) == 0);
    end
  endtask

  // sender pauses until every owed symbol is out and the walker is quiet
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_syms.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [BITS_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.bit_limit = v;
  endtask

  // well-formed streams mostly, some cut-off trees and some raw noise
  task automatic random_session();
    int kind;
    kind = $urandom_range(99);
    idle_on = ($urandom_range(3) != 0);
    stall_on = ($urandom_range(3) != 0);
    if (kind < 70) begin
      make_tree_bytes(pick_leaves());
      send_tree(tree_bytes.size());
      if ($urandom_range(9) == 0) send_item(OP_TREE, 8'($urandom_range(255)), 1'b0);
      send_codes($urandom_range(1, 8));
    end else if (kind < 85) begin
      make_tree_bytes(pick_leaves());
      send_tree($urandom_range(1, tree_bytes.size() - 1));
      send_codes($urandom_range(1, 3));
    end else begin
      repeat ($urandom_range(3, 8))
        send_item(op_t'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  // output side: check each accepted result transaction, then pick next stall
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        sb.check_symbol(symbol, last_of_byte, stream_done);
      if (hold_epoch != hold_seen) begin
        hold_seen = hold_epoch;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (stall_on && $urandom_range(99) < 20) begin
        stall_left = pick_gap_len() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    logic [BITS_W-1:0] lim;
    int phase_start;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_limit(31'd20);

    // directed: code before any tree, two-leaf tree, ignored extra tree byte
    send_item(OP_CODE, 8'hFF, 1'b0);
    tree_bytes = '{8'h00, LEAF_MARK, 8'h00, LEAF_MARK, 8'hFF};
    send_tree(5);
    send_item(OP_TREE, LEAF_MARK, 1'b0);
    // eight symbols per byte, then the limit cuts the third byte short
    send_item(OP_CODE, 8'h00, 1'b0);
    send_item(OP_CODE, 8'hFF, 1'b0);
    send_item(OP_CODE, 8'hA5, 1'b1);
    send_item(OP_CODE, 8'h5A, 1'b0);
    // single leaf tree counts bits but emits nothing
    tree_bytes = '{LEAF_MARK, LEAF_MARK};
    send_tree(2);
    send_item(OP_CODE, 8'hFF, 1'b0);
    // three leaves, internal markers at the edges around the leaf mark
    tree_bytes = '{8'hFF, LEAF_MARK, 8'h41, 8'h30, LEAF_MARK, 8'h42, LEAF_MARK, 8'h43};
    send_tree(8);
    send_item(OP_CODE, 8'h5B, 1'b0);
    wait_idle();

    // zero limit: bytes walk nothing
    write_limit('0);
    make_tree_bytes(3);
    send_tree(tree_bytes.size());
    send_codes(4);

    for (int p = 0; p < 5; p++) begin
      case (p)
        0, 4:    lim = LIMIT_MAX;
        1, 3:    lim = 31'($urandom_range(1, 60));
        default: lim = 31'($urandom);
      endcase
      wait_idle();
      write_limit(lim);
      phase_start = items_sent;
      if (p == 0) begin
        // receiver holds off while coded bytes keep coming
        idle_on = 1'b0;
        stall_on = 1'b0;
        make_tree_bytes(2);
        send_tree(tree_bytes.size());
        hold_epoch++;
        send_codes(32);
        wait_idle();
      end
      while (items_sent - phase_start < PHASE_ITEMS) random_session();
    end

    wait_idle();
    if (sb.expected_syms.size() != 0)
      sb.report($sformatf("%0d expected symbols never arrived", sb.expected_syms.size()));
    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/htwd_pkg.sv
sv/htwd_node_mem.sv
sv/htwd_tree_builder.sv
sv/htwd_walker.sv
sv/huffman_tree_walk_decoder.sv
tb/sv/tb_huffman_tree_walk_decoder.sv
